// ===== rtl/rfccu_pkg.sv =====
// ----------------------------------------------------------------------------
// RC channel frame decoder package
// Shared constants, beat types and the CRC-8 step used by the decoder.
// ----------------------------------------------------------------------------
package rfccu_pkg;

    localparam int MAX_FRAME    = 64;
    localparam int NUM_CHANNELS = 16;
    localparam int CH_BITS      = 11;
    localparam int CH_BASE      = 3;
    localparam int CH_VEC_W     = NUM_CHANNELS * CH_BITS;
    localparam int CH_BYTES     = (CH_VEC_W + 7) / 8;
    localparam int STORE_BYTES  = CH_BASE + CH_BYTES;
    localparam int POS_W        = $clog2(MAX_FRAME);
    localparam int IDX_W        = $clog2(NUM_CHANNELS);
    localparam int MAX_LEN      = MAX_FRAME - 2;

    localparam logic [7:0] ADDR_RC  = 8'hEE;
    localparam logic [7:0] TYPE_RC  = 8'h16;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic        last_channel;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_burst_stat;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/rfccu_parse.sv =====
// ----------------------------------------------------------------------------
// RC channel frame parser
// Tracks frame position, length and CRC, holds the header and channel bytes,
// and flags a frame that passes on its CRC beat.
// ----------------------------------------------------------------------------
module rfccu_parse (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_take,
    input  rfccu_pkg::t_in_beat                    i_beat,
    output logic                                   o_due,
    output logic                                   o_pass,
    output logic [rfccu_pkg::CH_BYTES*8-1:0]       o_chan_bytes
);

    logic                                    r_open;
    logic [rfccu_pkg::POS_W-1:0]             r_pos;
    logic [7:0]                              r_crc;
    logic [7:0]                              r_len;
    logic [rfccu_pkg::STORE_BYTES*8-1:0]     r_store;

    logic                                    n_open;
    logic [rfccu_pkg::POS_W-1:0]             n_pos;
    logic [7:0]                              n_crc;
    logic [7:0]                              n_len;
    logic [rfccu_pkg::STORE_BYTES*8-1:0]     n_store;

    logic                                    eff_open;
    logic [rfccu_pkg::POS_W-1:0]             eff_pos;
    logic [7:0]                              eff_crc;
    logic [7:0]                              eff_len;
    logic [7:0]                              b;
    logic                                    pass;

    always_comb begin
        b        = i_beat.rx_byte;
        eff_open = i_beat.frame_start | r_open;
        eff_pos  = i_beat.frame_start ? '0 : r_pos;
        eff_crc  = i_beat.frame_start ? 8'd0 : r_crc;
        eff_len  = i_beat.frame_start ? 8'd0 : r_len;
        n_open   = eff_open;
        n_pos    = eff_pos;
        n_crc    = eff_crc;
        n_len    = eff_len;
        n_store  = r_store;
        pass     = 1'b0;
        if (eff_open) begin
            for (int k = 0; k < rfccu_pkg::STORE_BYTES; k++) begin
                if (eff_pos == rfccu_pkg::POS_W'(k)) begin
                    n_store[k*8 +: 8] = b;
                end
            end
            n_pos = eff_pos + 1'b1;
            if (eff_pos == rfccu_pkg::POS_W'(1)) begin
                n_len = b;
                if (b == 8'd0 || b > 8'(rfccu_pkg::MAX_LEN)) begin
                    n_open = 1'b0;
                end
            end else if (eff_pos != '0) begin
                if (9'(eff_pos) <= 9'(eff_len)) begin
                    n_crc = rfccu_pkg::crc8_update(eff_crc, b);
                end else begin
                    n_open = 1'b0;
                    pass   = (b == eff_crc) && (n_store[7:0] == rfccu_pkg::ADDR_RC) &&
                             (n_store[23:16] == rfccu_pkg::TYPE_RC);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_pos   <= '0;
            r_crc   <= 8'd0;
            r_len   <= 8'd0;
            r_store <= '0;
        end else if (i_take) begin
            r_open  <= n_open;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_len   <= n_len;
            r_store <= n_store;
        end
    end

    assign o_due        = r_open && (r_pos >= rfccu_pkg::POS_W'(2)) &&
                          (9'(r_pos) == 9'(r_len) + 9'd1);
    assign o_pass       = i_take && pass;
    assign o_chan_bytes = n_store[rfccu_pkg::STORE_BYTES*8-1 : rfccu_pkg::CH_BASE*8];

endmodule

// ===== rtl/rfccu_burst.sv =====
// ----------------------------------------------------------------------------
// RC channel burst sender
// Holds the channel bytes of a passed frame and sends one channel per beat.
// ----------------------------------------------------------------------------
module rfccu_burst (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic [rfccu_pkg::CH_BYTES*8-1:0]   i_chan_bytes,
    input  logic                               i_stall,
    output logic                               o_valid,
    output rfccu_pkg::t_out_beat               o_beat,
    output rfccu_pkg::t_burst_stat             o_stat
);

    logic                                r_busy;
    logic [rfccu_pkg::IDX_W-1:0]         r_ch;
    logic [rfccu_pkg::CH_VEC_W-1:0]      r_buf;
    logic                                last;
    logic                                take;

    assign last = (r_ch == rfccu_pkg::IDX_W'(rfccu_pkg::NUM_CHANNELS - 1));
    assign take = r_busy && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ch   <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_ch   <= '0;
        end else if (take) begin
            r_busy <= !last;
            r_ch   <= last ? '0 : r_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_chan_bytes[rfccu_pkg::CH_VEC_W-1:0];
        end
    end

    assign o_valid              = r_busy;
    assign o_beat.channel_index = r_ch;
    assign o_beat.channel_value = r_buf[r_ch*rfccu_pkg::CH_BITS +: rfccu_pkg::CH_BITS];
    assign o_beat.last_channel  = last;
    assign o_stat.busy          = r_busy;
    assign o_stat.done          = take && last;

endmodule

// ===== rtl/rc_frame_crc_check_channel_unpack_top.sv =====
// ----------------------------------------------------------------------------
// RC channel frame decoder, top level
// Takes one received byte per beat and sends sixteen 11-bit channels for each
// frame that passes its address, type and CRC-8 checks.
// ----------------------------------------------------------------------------
// The input takes one byte per clock. A passing frame is detected on its CRC
// beat and its sixteen channel beats follow one per unstalled clock from the
// next cycle, out of a snapshot buffer, so later bytes keep flowing during the
// burst. The input stalls only when the next byte sits at the CRC position of
// an open frame while the burst buffer still holds channels not yet taken; it
// is released in the cycle the last channel beat leaves.
module rc_frame_crc_check_channel_unpack_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rfccu_pkg::t_in_beat    i_in_beat,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rfccu_pkg::t_out_beat   o_out_beat
);

    logic                                take;
    logic                                due;
    logic                                pass;
    logic [rfccu_pkg::CH_BYTES*8-1:0]    chan_bytes;
    rfccu_pkg::t_burst_stat              stat;

    assign o_in_stall = due && stat.busy && !stat.done;
    assign take       = i_in_valid && !o_in_stall;

    rfccu_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_beat       (i_in_beat),
        .o_due        (due),
        .o_pass       (pass),
        .o_chan_bytes (chan_bytes)
    );

    rfccu_burst u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (pass),
        .i_chan_bytes (chan_bytes),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_beat       (o_out_beat),
        .o_stat       (stat)
    );

endmodule

// ===== rtl/rfccu_check.sv =====
// ----------------------------------------------------------------------------
// RC channel frame decoder checker
// Port-level checks on the byte input and the channel burst, bound to the top
// level.
// ----------------------------------------------------------------------------
module rfccu_check (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  rfccu_pkg::t_in_beat    i_in_beat,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  rfccu_pkg::t_out_beat   o_out_beat
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_beat))
        else $error("stalled input beat changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_burst_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_beat.last_channel |=>
        o_out_valid && (o_out_beat.channel_index == $past(o_out_beat.channel_index) + 4'd1))
        else $error("channel burst broken");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.last_channel ==
        (o_out_beat.channel_index == 4'(rfccu_pkg::NUM_CHANNELS - 1))))
        else $error("last flag does not match channel index");

    a_burst_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) |-> o_out_beat.channel_index == 4'd0)
        else $error("burst does not start at channel zero");

endmodule

bind rc_frame_crc_check_channel_unpack_top rfccu_check u_rfccu_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// RC channel frame decoder testbench
// Drives framed serial bytes with random gaps and output stalls, predicts the
// sixteen channel beats of every passing frame and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class channel_scoreboard;

    logic [7:0]            frame_mem [rfccu_pkg::MAX_FRAME];
    int unsigned           next_pos;
    logic [7:0]            crc_acc;
    int unsigned           frame_len;
    bit                    line_idle;
    rfccu_pkg::t_out_beat  channels_due [$];
    int unsigned           errors;
    int unsigned           bytes_used;
    int unsigned           frames_ok;
    int unsigned           beats_out;

    function new();
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        next_pos   = 0;
        crc_acc    = 8'h00;
        frame_len  = 0;
        line_idle  = 1'b1;
        errors     = 0;
        bytes_used = 0;
        frames_ok  = 0;
        beats_out  = 0;
    endfunction

    static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
        return c;
    endfunction

    function logic [10:0] channel_of(int unsigned ch);
        int unsigned bitpos;
        int unsigned base;
        logic [23:0] w;
        bitpos = ch * rfccu_pkg::CH_BITS;
        base   = rfccu_pkg::CH_BASE + bitpos / 8;
        w      = {frame_mem[base + 2], frame_mem[base + 1], frame_mem[base]};
        return 11'(w >> (bitpos % 8));
    endfunction

    function int pending();
        return channels_due.size();
    endfunction

    function void note_byte(rfccu_pkg::t_in_beat beat);
        logic [7:0]            b;
        int unsigned           p;
        rfccu_pkg::t_out_beat  want;
        b = beat.rx_byte;
        if (beat.frame_start) begin
            line_idle = 1'b0;
            next_pos  = 0;
            crc_acc   = 8'h00;
            frame_len = 0;
        end
        if (line_idle) return;
        bytes_used++;
        p = next_pos;
        if (p < rfccu_pkg::MAX_FRAME) frame_mem[p] = b;
        next_pos = p + 1;
        if (p == 1) begin
            frame_len = b;
            if (b == 0 || b > rfccu_pkg::MAX_LEN) line_idle = 1'b1;
        end else if (p >= 2 && p <= frame_len) begin
            crc_acc = crc_step(crc_acc, b);
        end else if (p >= 2) begin
            line_idle = 1'b1;
            if (b == crc_acc && frame_mem[0] == rfccu_pkg::ADDR_RC &&
                frame_mem[2] == rfccu_pkg::TYPE_RC) begin
                frames_ok++;
                for (int unsigned ch = 0; ch < rfccu_pkg::NUM_CHANNELS; ch++) begin
                    want.channel_index = 4'(ch);
                    want.channel_value = channel_of(ch);
                    want.last_channel  = (ch == rfccu_pkg::NUM_CHANNELS - 1);
                    channels_due.push_back(want);
                end
            end
        end
    endfunction

    function void check_channel(rfccu_pkg::t_out_beat got);
        rfccu_pkg::t_out_beat want;
        if (channels_due.size() == 0) begin
            errors++;
            $display("%0t: channel beat with none due: expected nothing, got %h", $time, got);
            return;
        end
        want = channels_due.pop_front();
        beats_out++;
        if (got.channel_index !== want.channel_index) begin
            errors++;
            $display("%0t: channel_index expected %0d, got %0d", $time,
                     want.channel_index, got.channel_index);
        end
        if (got.channel_value !== want.channel_value) begin
            errors++;
            $display("%0t: channel_value expected %0d, got %0d", $time,
                     want.channel_value, got.channel_value);
        end
        if (got.last_channel !== want.last_channel) begin
            errors++;
            $display("%0t: last_channel expected %0d, got %0d", $time,
                     want.last_channel, got.last_channel);
        end
    endfunction

endclass

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    rfccu_pkg::t_in_beat   i_in_beat;
    logic                  o_out_valid;
    logic                  i_out_stall;
    rfccu_pkg::t_out_beat  o_out_beat;

    bit          idle_on = 1'b0;
    int unsigned cycle_count = 0;
    int          stall_left = 0;

    channel_scoreboard sb = new();

    rc_frame_crc_check_channel_unpack_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_channel(o_out_beat);
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!idle_on) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        rfccu_pkg::t_in_beat beat;
        beat.rx_byte     = b;
        beat.frame_start = s;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(beat);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
                              input logic [7:0] ftype, input t_fill fill,
                              input bit bad_crc, input int cut);
        logic [7:0] seq [$];
        logic [7:0] crc;
        logic [7:0] b;
        int         p;
        seq.push_back(addr);
        seq.push_back(len);
        crc = 8'h00;
        if (len == 0 || len > rfccu_pkg::MAX_LEN) begin
            repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom));
        end else begin
            for (p = 2; p <= len; p++) begin
                case (fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hFF;
                    default:   b = 8'($urandom);
                endcase
                if (p == 2) b = ftype;
                seq.push_back(b);
                crc = sb.crc_step(crc, b);
            end
            seq.push_back(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
        end
        if (cut > 0 && cut < seq.size()) seq = seq[0:cut-1];
        for (p = 0; p < seq.size(); p++) send_byte(seq[p], p == 0);
    endtask

    function automatic int channel_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return rfccu_pkg::CH_BASE + rfccu_pkg::CH_BYTES - 1;
        if (r == 7) return $urandom_range(1, rfccu_pkg::CH_BASE + rfccu_pkg::CH_BYTES - 2);
        if (r == 8) begin
            return $urandom_range(rfccu_pkg::CH_BASE + rfccu_pkg::CH_BYTES,
                                  rfccu_pkg::MAX_LEN - 1);
        end
        return rfccu_pkg::MAX_LEN;
    endfunction

    initial begin
        int         r;
        int         len;
        int         cut;
        bit         bad;
        bit         drained;
        logic [7:0] addr;
        logic [7:0] ftype;
        t_fill      fill;

        drained = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_beat  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(rfccu_pkg::ADDR_RC, 8'd4, rfccu_pkg::TYPE_RC, FILL_ONES, 1'b0, 0);
        send_frame(rfccu_pkg::ADDR_RC, 8'd1, rfccu_pkg::TYPE_RC, FILL_RANDOM, 1'b0, 0);
        send_frame(rfccu_pkg::ADDR_RC, 8'd0, rfccu_pkg::TYPE_RC, FILL_RANDOM, 1'b0, 0);
        send_byte(8'h00, 1'b0);
        send_frame(rfccu_pkg::ADDR_RC, 8'(rfccu_pkg::MAX_LEN + 1), rfccu_pkg::TYPE_RC,
                   FILL_RANDOM, 1'b0, 0);
        send_frame(rfccu_pkg::ADDR_RC, 8'd2, rfccu_pkg::TYPE_RC, FILL_ZERO, 1'b0, 3);
        send_frame(rfccu_pkg::ADDR_RC, 8'd2, rfccu_pkg::TYPE_RC, FILL_ZERO, 1'b1, 0);
        send_frame(8'h00, 8'd2, rfccu_pkg::TYPE_RC, FILL_ZERO, 1'b0, 0);
        send_frame(rfccu_pkg::ADDR_RC, 8'd2, 8'h00, FILL_ZERO, 1'b0, 0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_frame(rfccu_pkg::ADDR_RC, 8'd2, rfccu_pkg::TYPE_RC, FILL_ZERO, 1'b0, 0);

        while (sb.bytes_used < 340) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!drained && sb.bytes_used >= 170) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            r     = $urandom_range(0, 99);
            len   = channel_len();
            addr  = rfccu_pkg::ADDR_RC;
            ftype = rfccu_pkg::TYPE_RC;
            bad   = 1'b0;
            cut   = 0;
            fill  = (r % 10 == 0) ? FILL_ONES : (r % 10 == 1) ? FILL_ZERO : FILL_RANDOM;
            if (r >= 91) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                if (r >= 86) begin
                    len = $urandom_range(0, 1) ? 0 : $urandom_range(rfccu_pkg::MAX_LEN + 1, 255);
                end else if (r >= 78) cut = $urandom_range(1, len + 1);
                else if (r >= 73) do ftype = 8'($urandom); while (ftype == rfccu_pkg::TYPE_RC);
                else if (r >= 68) do addr = 8'($urandom); while (addr == rfccu_pkg::ADDR_RC);
                else if (r >= 60) bad = 1'b1;
                send_frame(addr, 8'(len), ftype, fill, bad, cut);
            end
        end

        idle_on = 1'b0;
        repeat (3) begin
            send_frame(rfccu_pkg::ADDR_RC, 8'(rfccu_pkg::CH_BASE + rfccu_pkg::CH_BYTES - 1),
                       rfccu_pkg::TYPE_RC, FILL_RANDOM, 1'b0, 0);
        end
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (40) @(posedge i_clk);

        $display("covered %0d frame bytes, %0d decoded frames, %0d channel beats checked",
                 sb.bytes_used, sb.frames_ok, sb.beats_out);
        $display("with random input gaps, output stalls and one full drain mid-run");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
